FILE: hw/rtl/met_pkg.sv
// shared types, constants and codes for the escape-time engine
package met_pkg;

  // field widths fixed by the interface
  localparam int COORD_W   = 12;
  localparam int DIM_W     = 13;
  localparam int LIMIT_W   = 24;
  localparam int COUNT_W   = 25;
  localparam int SPAN_W    = LIMIT_W + 1;
  localparam int STEP_W    = 63;
  localparam int WORD_W    = 64;
  localparam int PROD_W    = 128;
  localparam int ADDR_W    = 6;

  // parameter defaults
  localparam int MAX_DIM_DEF     = 4096;
  localparam int FRAC_BITS_DEF   = 56;
  localparam int FIRST_SPAN_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  // register reset values that do not depend on the number format
  localparam logic [LIMIT_W-1:0] RST_LIMIT = LIMIT_W'(256);
  localparam logic [DIM_W-1:0]   RST_DIM   = DIM_W'(1024);

  // register map, one 64-bit slot per register
  typedef enum logic [2:0] {
    REG_ORIGIN_RE = 3'd0,
    REG_ORIGIN_IM = 3'd1,
    REG_STEP_RE   = 3'd2,
    REG_STEP_IM   = 3'd3,
    REG_LIMIT     = 3'd4,
    REG_RADIUS    = 3'd5,
    REG_WIDTH     = 3'd6,
    REG_HEIGHT    = 3'd7
  } reg_idx_t;

  // result classification
  typedef enum logic [1:0] {
    OUTCOME_ESCAPED = 2'd0,
    OUTCOME_BULB    = 2'd1,
    OUTCOME_BOUNDED = 2'd2
  } outcome_t;

  // back-end sequencer states
  typedef enum logic [4:0] {
    ST_IDLE, ST_CR, ST_CI, ST_GATE, ST_YY, ST_XX, ST_Q, ST_LHS, ST_BULB2,
    ST_INIT, ST_SPAN, ST_CHECK, ST_QR, ST_QI, ST_ZI, ST_EXT, ST_MAG,
    ST_M1, ST_M2, ST_DONE
  } state_t;

  // configuration seen by the engine
  typedef struct packed {
    logic [WORD_W-1:0]  origin_real;
    logic [WORD_W-1:0]  origin_imag;
    logic [STEP_W-1:0]  step_real;
    logic [STEP_W-1:0]  step_imag;
    logic [LIMIT_W-1:0] iteration_limit;
    logic [STEP_W-1:0]  escape_radius_sq;
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
  } cfg_t;

  // one queued pixel
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pix_t;

  // multiplier request and response
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

endpackage

FILE: hw/rtl/mandelbrot_escape_time_top.sv
// Escape-time engine: pixel coordinates in, classification and iteration count out.
// Input channel: push/full carries pixel_x and pixel_y; a transfer happens when push is
// high and full is low. Pixels outside image_width by image_height are taken and dropped.
// Result channel: empty/pop; the oldest result sits on the out_ ports while empty is low
// and leaves on a transfer with pop high.
// Configuration: APB writes at byte address 8*index, pready tied high, readback supported.
// Flow: the pixel is mapped to c and its range is checked; the bulb tests run only
// when c lies within |re| < 2 and |im| < 2. Iteration is set up in INIT and SPAN, and the
// check span doubles, up to the iteration limit, each time it runs out; after escape,
// the two extra iterations and the magnitude follow. One pixel is worked on at a
// time; its pace is set by the single shared multiplier, which builds each 64x64 product
// from 32x32 partial products, and 3 products are needed per iteration.
// A four-entry queue in front of the engine keeps taking pixels while it works, and a
// one-entry output register holds a finished result while the receiver stalls; the
// engine may finish the next pixel, then waits on that register before handing it over.
// Reset: synchronous, active low; clears all control state and loads register defaults.
module mandelbrot_escape_time_top #(
  parameter int MAX_DIM          = met_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS        = met_pkg::FRAC_BITS_DEF,
  parameter int FIRST_CHECK_SPAN = met_pkg::FIRST_SPAN_DEF,
  parameter int QUEUE_DEPTH      = met_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [met_pkg::COORD_W-1:0]  in_pixel_x,
  input  logic [met_pkg::COORD_W-1:0]  in_pixel_y,
  output logic                         empty,
  input  logic                         pop,
  output logic [met_pkg::COORD_W-1:0]  out_x,
  output logic [met_pkg::COORD_W-1:0]  out_y,
  output logic [1:0]                   out_outcome,
  output logic [met_pkg::COUNT_W-1:0]  out_iteration_count,
  output logic [met_pkg::WORD_W-1:0]   out_magnitude_sq,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [met_pkg::ADDR_W-1:0]   paddr,
  input  logic [met_pkg::WORD_W-1:0]   pwdata,
  output logic [met_pkg::WORD_W-1:0]   prdata,
  output logic                         pready
);

  localparam logic [63:0] RST_ORIGIN_RE = -(64'd1 << (FRAC_BITS + 1));
  localparam logic [63:0] RST_ORIGIN_IM = -(64'd1 << FRAC_BITS);
  localparam logic [met_pkg::STEP_W-1:0] RST_STEP =
    met_pkg::STEP_W'(64'd1 << (FRAC_BITS - 9));
  localparam logic [met_pkg::STEP_W-1:0] RST_RADIUS =
    met_pkg::STEP_W'(64'd1 << (FRAC_BITS + 2));

  logic [63:0]                  origin_real_r, origin_imag_r;
  logic [met_pkg::STEP_W-1:0]   step_real_r, step_imag_r, radius_r;
  logic [met_pkg::LIMIT_W-1:0]  limit_r;
  logic [met_pkg::DIM_W-1:0]    width_r, height_r;
  met_pkg::reg_idx_t            reg_idx;
  logic                         wr_en;
  met_pkg::cfg_t                cfg;
  logic                         q_push, q_full, q_pop, q_empty;
  met_pkg::pix_t                q_wdata, q_rdata;
  met_pkg::mul_req_t            mul_req;
  met_pkg::mul_rsp_t            mul_rsp;

  assign pready  = 1'b1;
  assign reg_idx = met_pkg::reg_idx_t'(paddr[5:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_real_r <= RST_ORIGIN_RE;
      origin_imag_r <= RST_ORIGIN_IM;
      step_real_r   <= RST_STEP;
      step_imag_r   <= RST_STEP;
      limit_r       <= met_pkg::RST_LIMIT;
      radius_r      <= RST_RADIUS;
      width_r       <= met_pkg::RST_DIM;
      height_r      <= met_pkg::RST_DIM;
    end else if (wr_en) begin
      case (reg_idx)
        met_pkg::REG_ORIGIN_RE: origin_real_r <= pwdata;
        met_pkg::REG_ORIGIN_IM: origin_imag_r <= pwdata;
        met_pkg::REG_STEP_RE:   step_real_r   <= pwdata[62:0];
        met_pkg::REG_STEP_IM:   step_imag_r   <= pwdata[62:0];
        met_pkg::REG_LIMIT:     limit_r       <= pwdata[23:0];
        met_pkg::REG_RADIUS:    radius_r      <= pwdata[62:0];
        met_pkg::REG_WIDTH:     width_r       <= pwdata[12:0];
        met_pkg::REG_HEIGHT:    height_r      <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      met_pkg::REG_ORIGIN_RE: prdata = origin_real_r;
      met_pkg::REG_ORIGIN_IM: prdata = origin_imag_r;
      met_pkg::REG_STEP_RE:   prdata = 64'(step_real_r);
      met_pkg::REG_STEP_IM:   prdata = 64'(step_imag_r);
      met_pkg::REG_LIMIT:     prdata = 64'(limit_r);
      met_pkg::REG_RADIUS:    prdata = 64'(radius_r);
      met_pkg::REG_WIDTH:     prdata = 64'(width_r);
      met_pkg::REG_HEIGHT:    prdata = 64'(height_r);
      default:                prdata = '0;
    endcase
  end

  // configuration bundle for the engine
  always_comb begin
    cfg.origin_real      = origin_real_r;
    cfg.origin_imag      = origin_imag_r;
    cfg.step_real        = step_real_r;
    cfg.step_imag        = step_imag_r;
    cfg.iteration_limit  = limit_r;
    cfg.escape_radius_sq = radius_r;
    cfg.image_width      = width_r;
    cfg.image_height     = height_r;
  end

  met_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .push         (push),
    .full         (full),
    .pixel_x      (in_pixel_x),
    .pixel_y      (in_pixel_y),
    .image_width  (cfg.image_width),
    .image_height (cfg.image_height),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  met_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  met_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  met_back #(
    .FRAC_BITS        (FRAC_BITS),
    .FIRST_CHECK_SPAN (FIRST_CHECK_SPAN)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .mul_req     (mul_req),
    .mul_rsp     (mul_rsp),
    .out_empty   (empty),
    .out_pop     (pop),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_outcome (out_outcome),
    .out_count   (out_iteration_count),
    .out_mag     (out_magnitude_sq)
  );

  // multiplier is never restarted while a product is in flight
  a_mul_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  // an escaped result always carries the extra iterations in its count
  a_escape_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_outcome == met_pkg::OUTCOME_ESCAPED)
      |-> out_iteration_count >= met_pkg::COUNT_W'(3))
    else $error("escaped result with short count");

  // a bounded or bulb result carries no count and no magnitude
  a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_outcome != met_pkg::OUTCOME_ESCAPED)
      |-> (out_iteration_count == '0 && out_magnitude_sq == '0))
    else $error("inside result with nonzero count or magnitude");

endmodule

FILE: hw/rtl/met_front.sv
// front end: takes pixels, drops those outside the image, queues the rest
module met_front #(
  parameter int MAX_DIM = met_pkg::MAX_DIM_DEF
) (
  input  logic                         push,
  output logic                         full,
  input  logic [met_pkg::COORD_W-1:0]  pixel_x,
  input  logic [met_pkg::COORD_W-1:0]  pixel_y,
  input  logic [met_pkg::DIM_W-1:0]    image_width,
  input  logic [met_pkg::DIM_W-1:0]    image_height,
  input  logic                         q_full,
  output logic                         q_push,
  output met_pkg::pix_t                q_data
);

  localparam int LIM_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (LIM_W > met_pkg::DIM_W) ? LIM_W : met_pkg::DIM_W;
  localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(MAX_DIM);

  logic [CMP_W-1:0] w_lim, h_lim;
  logic             in_bounds;

  // clip the programmed size to the supported size
  always_comb begin
    w_lim = (CMP_W'(image_width) < DIM_MAX) ? CMP_W'(image_width) : DIM_MAX;
    h_lim = (CMP_W'(image_height) < DIM_MAX) ? CMP_W'(image_height) : DIM_MAX;
    in_bounds = (CMP_W'(pixel_x) < w_lim) && (CMP_W'(pixel_y) < h_lim);
  end

  // a transfer outside the image is taken and dropped
  assign full     = q_full;
  assign q_push   = push && !q_full && in_bounds;
  assign q_data.x = pixel_x;
  assign q_data.y = pixel_y;

endmodule

FILE: hw/rtl/met_queue.sv
// small register queue between front end and engine
module met_queue #(
  parameter int DEPTH = met_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  met_pkg::pix_t wdata,
  output logic          full,
  input  logic          pop,
  output met_pkg::pix_t rdata,
  output logic          empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  met_pkg::pix_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

FILE: hw/rtl/met_mul.sv
// shared 64x64 unsigned multiplier, one 32x32 partial product per cycle
module met_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  met_pkg::mul_req_t req,
  output met_pkg::mul_rsp_t rsp
);

  logic [met_pkg::WORD_W-1:0] a_r, b_r, pp_r;
  logic [met_pkg::PROD_W-1:0] acc_r, pp_sh;
  logic [2:0]                 cnt_r;
  logic [1:0]                 acc_k;
  logic                       busy_r, done_r;
  logic [31:0]                a_sel, b_sel;
  logic [met_pkg::WORD_W-1:0] pp;

  // select halves for the current partial product
  always_comb begin
    a_sel = cnt_r[1] ? a_r[63:32] : a_r[31:0];
    b_sel = cnt_r[0] ? b_r[63:32] : b_r[31:0];
    pp    = a_sel * b_sel;
  end

  // align the registered partial product
  always_comb begin
    acc_k = 2'(cnt_r - 3'd1);
    case (acc_k)
      2'd0:    pp_sh = {64'b0, pp_r};
      2'd3:    pp_sh = {pp_r, 64'b0};
      default: pp_sh = {32'b0, pp_r, 32'b0};
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands, partial product and accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r != 3'd4) pp_r <= pp;
      if (cnt_r != 3'd0) acc_r <= acc_r + pp_sh;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

FILE: hw/rtl/met_back.sv
// engine: coordinate mapping, bulb tests, iteration with cycle check, escape magnitude
module met_back #(
  parameter int FRAC_BITS        = met_pkg::FRAC_BITS_DEF,
  parameter int FIRST_CHECK_SPAN = met_pkg::FIRST_SPAN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  met_pkg::cfg_t                 cfg,
  input  logic                          q_empty,
  input  met_pkg::pix_t                 q_data,
  output logic                          q_pop,
  output met_pkg::mul_req_t             mul_req,
  input  met_pkg::mul_rsp_t             mul_rsp,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [met_pkg::COORD_W-1:0]   out_x,
  output logic [met_pkg::COORD_W-1:0]   out_y,
  output logic [1:0]                    out_outcome,
  output logic [met_pkg::COUNT_W-1:0]   out_count,
  output logic [met_pkg::WORD_W-1:0]    out_mag
);

  localparam logic signed [63:0] ONE       = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] TWO       = ONE <<< 1;
  localparam logic signed [63:0] QUARTER   = ONE >>> 2;
  localparam logic signed [63:0] SIXTEENTH = ONE >>> 4;
  localparam logic signed [63:0] INT_MAX   = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] INT_MIN   = {1'b1, 63'b0};
  localparam int MAG_SHIFT = 2 * FRAC_BITS - 48;
  localparam logic [met_pkg::SPAN_W-1:0] FIRST_SPAN =
    met_pkg::SPAN_W'(FIRST_CHECK_SPAN);

  met_pkg::state_t state_r, state_nxt;

  logic signed [63:0] cr_r, ci_r, xm_r, yy_r, q_r, zr_r, zi_r, sr_r, si_r;
  logic signed [63:0] qr_r, qi_r;
  logic [met_pkg::PROD_W-1:0]  m1_r;
  logic                        neg_r, esc_r, ext_r, mul_neg;
  logic [met_pkg::LIMIT_W-1:0] n_r;
  logic [met_pkg::SPAN_W-1:0]  span_r, span_dbl, limit_x;
  logic [met_pkg::COORD_W-1:0] x_r, y_r;
  met_pkg::outcome_t           res_outcome_r;
  logic [met_pkg::COUNT_W-1:0] res_count_r;
  logic [met_pkg::WORD_W-1:0]  res_mag_r;
  logic                        out_valid_r;
  met_pkg::outcome_t           out_outcome_r;
  logic [met_pkg::COORD_W-1:0] out_x_r, out_y_r;
  logic [met_pkg::COUNT_W-1:0] out_count_r;
  logic [met_pkg::WORD_W-1:0]  out_mag_r;

  logic                        done, slot_free, in_range, lhs_in, bulb2_in;
  logic                        escape, cycle, more;
  logic signed [127:0]         wide_s, sh_f, sh_f1;
  logic signed [63:0]          ms_f, ms_f1, qx, cp1, zr_new, zi_new, coord_val;
  logic [63:0]                 coord_o;
  logic [met_pkg::PROD_W-1:0]  msum, mshift;

  // product fits in 64 signed bits or saturates by its sign
  function automatic logic signed [63:0] fit64(input logic signed [127:0] v);
    if (&v[127:63] || ~|v[127:63]) fit64 = v[63:0];
    else                           fit64 = v[127] ? INT_MIN : INT_MAX;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sat_add = s[64] ? INT_MIN : INT_MAX;
    else                sat_add = s[63:0];
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    mag = a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] coord(input logic [63:0] o,
                                               input logic [127:0] p);
    logic [63:0] room;
    room = 64'h7FFF_FFFF_FFFF_FFFF - o;
    if (|p[127:64] || p[63:0] > room) coord = INT_MAX;
    else                              coord = $signed(o + p[63:0]);
  endfunction

  assign done = mul_rsp.done;

  // signed, truncated and saturated product
  always_comb begin
    wide_s = neg_r ? -$signed(mul_rsp.prod) : $signed(mul_rsp.prod);
    sh_f   = wide_s >>> FRAC_BITS;
    sh_f1  = wide_s >>> (FRAC_BITS - 1);
    ms_f   = fit64(sh_f);
    ms_f1  = fit64(sh_f1);
  end

  // decisions and derived operands
  always_comb begin
    coord_o  = (state_r == met_pkg::ST_CR) ? cfg.origin_real : cfg.origin_imag;
    coord_val = coord(coord_o, mul_rsp.prod);
    in_range = (cr_r > -TWO) && (cr_r < TWO) && (ci_r > -TWO) && (ci_r < TWO);
    qx       = q_r + xm_r;
    cp1      = cr_r + ONE;
    lhs_in   = ms_f < (yy_r >>> 2);
    bulb2_in = (ms_f + yy_r) < SIXTEENTH;
    escape   = ({1'b0, qr_r} + {1'b0, ms_f}) > {2'b0, cfg.escape_radius_sq};
    zi_new   = sat_add(ms_f1, ci_r);
    zr_new   = sat_add(qr_r - qi_r, cr_r);
    cycle    = (zr_new == sr_r) && (zi_new == si_r);
    limit_x  = {1'b0, cfg.iteration_limit};
    span_dbl = span_r << 1;
    more     = {1'b0, n_r} < span_r;
    msum     = m1_r + mul_rsp.prod;
    mshift   = msum >> MAG_SHIFT;
    slot_free = !out_valid_r || out_pop;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      met_pkg::ST_IDLE:  if (!q_empty) state_nxt = met_pkg::ST_CR;
      met_pkg::ST_CR:    if (done) state_nxt = met_pkg::ST_CI;
      met_pkg::ST_CI:    if (done) state_nxt = met_pkg::ST_GATE;
      met_pkg::ST_GATE:  state_nxt = in_range ? met_pkg::ST_YY : met_pkg::ST_INIT;
      met_pkg::ST_YY:    if (done) state_nxt = met_pkg::ST_XX;
      met_pkg::ST_XX:    if (done) state_nxt = met_pkg::ST_Q;
      met_pkg::ST_Q:     state_nxt = met_pkg::ST_LHS;
      met_pkg::ST_LHS: begin
        if (done) state_nxt = lhs_in ? met_pkg::ST_DONE : met_pkg::ST_BULB2;
      end
      met_pkg::ST_BULB2: begin
        if (done) state_nxt = bulb2_in ? met_pkg::ST_DONE : met_pkg::ST_INIT;
      end
      met_pkg::ST_INIT:  state_nxt = met_pkg::ST_SPAN;
      met_pkg::ST_SPAN:  state_nxt = met_pkg::ST_CHECK;
      met_pkg::ST_CHECK: begin
        if (more)                 state_nxt = met_pkg::ST_QR;
        else if (span_r == limit_x) state_nxt = met_pkg::ST_DONE;
        else                      state_nxt = met_pkg::ST_SPAN;
      end
      met_pkg::ST_QR:    if (done) state_nxt = met_pkg::ST_QI;
      met_pkg::ST_QI:    if (done) state_nxt = met_pkg::ST_ZI;
      met_pkg::ST_ZI: begin
        if (done) begin
          if (esc_r)      state_nxt = ext_r ? met_pkg::ST_MAG : met_pkg::ST_EXT;
          else if (cycle) state_nxt = met_pkg::ST_DONE;
          else            state_nxt = met_pkg::ST_CHECK;
        end
      end
      met_pkg::ST_EXT:   state_nxt = met_pkg::ST_QR;
      met_pkg::ST_MAG:   state_nxt = met_pkg::ST_M1;
      met_pkg::ST_M1:    if (done) state_nxt = met_pkg::ST_M2;
      met_pkg::ST_M2:    if (done) state_nxt = met_pkg::ST_DONE;
      met_pkg::ST_DONE:  if (slot_free) state_nxt = met_pkg::ST_IDLE;
      default:           state_nxt = met_pkg::ST_IDLE;
    endcase
  end

  // multiplier issue and queue pop
  always_comb begin
    q_pop         = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a     = mag(zr_r);
    mul_req.b     = mag(zr_r);
    mul_neg       = 1'b0;
    case (state_r)
      met_pkg::ST_IDLE: begin
        q_pop         = !q_empty;
        mul_req.start = !q_empty;
        mul_req.a     = 64'(q_data.x);
        mul_req.b     = {1'b0, cfg.step_real};
      end
      met_pkg::ST_CR: begin
        mul_req.start = done;
        mul_req.a     = 64'(y_r);
        mul_req.b     = {1'b0, cfg.step_imag};
      end
      met_pkg::ST_GATE: begin
        mul_req.start = in_range;
        mul_req.a     = mag(ci_r);
        mul_req.b     = mag(ci_r);
      end
      met_pkg::ST_YY: begin
        mul_req.start = done;
        mul_req.a     = mag(xm_r);
        mul_req.b     = mag(xm_r);
      end
      met_pkg::ST_Q: begin
        mul_req.start = 1'b1;
        mul_req.a     = mag(q_r);
        mul_req.b     = mag(qx);
        mul_neg       = q_r[63] ^ qx[63];
      end
      met_pkg::ST_LHS: begin
        mul_req.start = done && !lhs_in;
        mul_req.a     = mag(cp1);
        mul_req.b     = mag(cp1);
      end
      met_pkg::ST_CHECK: mul_req.start = more;
      met_pkg::ST_EXT:   mul_req.start = 1'b1;
      met_pkg::ST_MAG:   mul_req.start = 1'b1;
      met_pkg::ST_QR, met_pkg::ST_M1: begin
        mul_req.start = done;
        mul_req.a     = mag(zi_r);
        mul_req.b     = mag(zi_r);
      end
      met_pkg::ST_QI: begin
        mul_req.start = done;
        mul_req.a     = mag(zr_r);
        mul_req.b     = mag(zi_r);
        mul_neg       = zr_r[63] ^ zi_r[63];
      end
      default: mul_req.start = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= met_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == met_pkg::ST_DONE && slot_free) out_valid_r <= 1'b1;
      else if (out_pop)                             out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (mul_req.start) neg_r <= mul_neg;
    case (state_r)
      met_pkg::ST_IDLE: begin
        x_r           <= q_data.x;
        y_r           <= q_data.y;
        esc_r         <= 1'b0;
        ext_r         <= 1'b0;
        res_outcome_r <= met_pkg::OUTCOME_BOUNDED;
        res_count_r   <= '0;
        res_mag_r     <= '0;
      end
      met_pkg::ST_CR:   if (done) cr_r <= coord_val;
      met_pkg::ST_CI:   if (done) ci_r <= coord_val;
      met_pkg::ST_GATE: xm_r <= cr_r - QUARTER;
      met_pkg::ST_YY:   if (done) yy_r <= ms_f;
      met_pkg::ST_XX:   if (done) q_r <= ms_f + yy_r;
      met_pkg::ST_LHS:  if (done && lhs_in) res_outcome_r <= met_pkg::OUTCOME_BULB;
      met_pkg::ST_BULB2: begin
        if (done && bulb2_in) res_outcome_r <= met_pkg::OUTCOME_BULB;
      end
      met_pkg::ST_INIT: begin
        zr_r   <= cr_r;
        zi_r   <= ci_r;
        n_r    <= '0;
        span_r <= FIRST_SPAN;
      end
      met_pkg::ST_SPAN: begin
        sr_r   <= zr_r;
        si_r   <= zi_r;
        span_r <= (span_dbl > limit_x) ? limit_x : span_dbl;
      end
      met_pkg::ST_QR: if (done) qr_r <= ms_f;
      met_pkg::ST_QI: begin
        if (done) begin
          qi_r <= ms_f;
          if (escape) esc_r <= 1'b1;
        end
      end
      met_pkg::ST_ZI: begin
        if (done) begin
          zi_r <= zi_new;
          zr_r <= zr_new;
          if (esc_r)       ext_r <= 1'b1;
          else if (!cycle) n_r <= n_r + 1'b1;
        end
      end
      met_pkg::ST_M1: if (done) m1_r <= mul_rsp.prod;
      met_pkg::ST_M2: begin
        if (done) begin
          res_outcome_r <= met_pkg::OUTCOME_ESCAPED;
          res_count_r   <= met_pkg::COUNT_W'(n_r) + met_pkg::COUNT_W'(3);
          res_mag_r     <= (|mshift[127:64]) ? '1 : mshift[63:0];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == met_pkg::ST_DONE && slot_free) begin
      out_x_r       <= x_r;
      out_y_r       <= y_r;
      out_outcome_r <= res_outcome_r;
      out_count_r   <= res_count_r;
      out_mag_r     <= res_mag_r;
    end
  end

  assign out_empty   = !out_valid_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;
  assign out_outcome = out_outcome_r;
  assign out_count   = out_count_r;
  assign out_mag     = out_mag_r;

endmodule
